FILE: rtl/anisotropic_diffusion_pass_macros.svh
// ----------------------------------------------------------------------------
// anisotropic diffusion pass assertion macros
// shared concurrent assertion helpers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ANISOTROPIC_DIFFUSION_PASS_MACROS_SVH
`define ANISOTROPIC_DIFFUSION_PASS_MACROS_SVH

// property must hold at every clock edge outside reset
`define AD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define AD_NEVER(lbl, cond, msg) \
    `AD_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/ad_pkg.sv
// ----------------------------------------------------------------------------
// ad_pkg
// shared types, constants and the exponential coefficient table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ad_pkg;

    localparam int          EXP_SIZE    = 256;
    localparam int          QIDX_SHIFT  = 27;
    localparam logic [95:0] EXP_STEP_Q32 = 96'd4162825044;

    typedef logic [12:0] t_exp_rom [EXP_SIZE];

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CALC,
        S_EMIT,
        S_DRAIN,
        S_DWAIT
    } t_state;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LAMBDA = 2'd2,
        REG_ISIGMA = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] lambda_q12;
        logic [19:0] inv_sigma_sq;
    } t_dif_cfg;

    // exp(-k/32) in q0.12, built by repeated q0.32 multiplication
    function automatic t_exp_rom exp_rom_build();
        t_exp_rom    rom;
        logic [95:0] acc;
        acc = 96'd1 << 32;
        for (int k = 0; k < EXP_SIZE; k++) begin
            rom[k] = 13'((acc + (96'd1 << 19)) >> 20);
            acc    = (acc * EXP_STEP_Q32) >> 32;
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = exp_rom_build();

endpackage

FILE: rtl/ad_ram.sv
// ----------------------------------------------------------------------------
// ad_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ad_diffuse.sv
// ----------------------------------------------------------------------------
// ad_diffuse
// six stage perona-malik update of one pixel from its four neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ad_diffuse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [15:0]      i_p,
    input  logic [15:0]      i_nb [4],
    input  ad_pkg::t_dif_cfg i_cfg,
    output logic             o_done,
    output logic [15:0]      o_pix
);

    import ad_pkg::*;

    logic [5:0]         r_vld;
    logic [15:0]        r_p;
    logic signed [16:0] r_d   [4];
    logic [31:0]        r_sq  [4];
    logic [7:0]         r_idx [4];
    logic [3:0]         r_ok;
    logic signed [29:0] r_cd  [4];
    logic signed [31:0] r_s;
    logic signed [42:0] r_v;
    logic [15:0]        r_pix;

    logic signed [16:0] w_d  [4];
    logic signed [33:0] w_dd [4];
    logic [51:0]        w_qp [4];
    logic [12:0]        w_c  [4];
    logic signed [30:0] w_cd [4];
    logic signed [43:0] w_lv;
    logic signed [42:0] w_vr;
    logic signed [18:0] w_delta;
    logic signed [19:0] w_res;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_d[i]  = signed'({1'b0, i_nb[i]}) - signed'({1'b0, i_p});
            w_dd[i] = w_d[i] * w_d[i];
            w_qp[i] = r_sq[i] * i_cfg.inv_sigma_sq;
            w_c[i]  = r_ok[i] ? EXP_ROM[r_idx[i]] : 13'd0;
            w_cd[i] = signed'({1'b0, w_c[i]}) * r_d[i];
        end
        w_lv    = signed'({1'b0, i_cfg.lambda_q12}) * r_s;
        // round half up, floor division by 2^24
        w_vr    = r_v + 43'sd8388608;
        w_delta = 19'(w_vr >>> 24);
        w_res   = signed'({4'd0, r_p}) + 20'(w_delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= i_p;
            for (int i = 0; i < 4; i++) begin
                r_d[i]  <= w_d[i];
                r_sq[i] <= 32'(unsigned'(w_dd[i]));
            end
        end
        if (r_vld[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_idx[i] <= w_qp[i][QIDX_SHIFT +: 8];
                r_ok[i]  <= (w_qp[i][51:QIDX_SHIFT+8] == '0);
            end
        end
        if (r_vld[1]) begin
            for (int i = 0; i < 4; i++) begin
                r_cd[i] <= 30'(w_cd[i]);
            end
        end
        if (r_vld[2]) begin
            r_s <= 32'(r_cd[0]) + 32'(r_cd[1]) + 32'(r_cd[2]) + 32'(r_cd[3]);
        end
        if (r_vld[3]) begin
            r_v <= 43'(w_lv);
        end
        if (r_vld[4]) begin
            priority if (w_res < 0) begin
                r_pix <= 16'd0;
            end else if (w_res > 20'sd65535) begin
                r_pix <= 16'hFFFF;
            end else begin
                r_pix <= w_res[15:0];
            end
        end
    end

    assign o_done = r_vld[5];
    assign o_pix  = r_pix;

endmodule

FILE: rtl/anisotropic_diffusion_pass.sv
// ----------------------------------------------------------------------------
// anisotropic_diffusion_pass
// one perona-malik diffusion pass over a raster stream of q0.16 gray pixels
// ----------------------------------------------------------------------------
// usage: pixels enter on the s_axis channel in raster order, tuser[0] marks
// the first pixel of a frame. diffused pixels leave on m_axis in raster
// order, one row plus one pixel behind the input. border pixels pass as is.
// tlast marks the last pixel of the frame, tuser[0] the last word that an
// input word produced. after the last input pixel of a frame, further input
// words (tuser low, data ignored) each drain up to four remaining words.
// a word marked frame start always restarts, dropping anything pending.
// an interior pixel passes the six stage coefficient pipeline behind the
// line buffer read before its output word is loaded; border pixels and
// drain words bypass that pipeline.
// line buffers are two srams with a registered read port, read at accept and
// written back in the next cycle, so items are handled one at a time.
// an output register sits on m_axis: a new word is accepted while a finished
// word still waits for m_axis_tready. reset restores the register defaults
// and starts at row 0, column 0; line buffers are not cleared.
// configuration is via the apb port, registers at byte addresses 0,4,8,12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anisotropic_diffusion_pass_macros.svh"

module anisotropic_diffusion_pass #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    // output pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // [0] burst_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import ad_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);      // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);  // clamped width
    localparam int DW = $clog2(MAX_WIDTH + 2);  // drain count and position

    // configuration registers
    logic [10:0] r_image_width;
    logic [12:0] r_image_height;
    logic [10:0] r_lambda_q12;
    logic [19:0] r_inv_sigma_sq;

    // position and drain state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_col;
    logic [11:0]    r_row;
    logic           r_done;
    logic [DW-1:0]  r_left;
    logic [DW-1:0]  r_pos;
    logic [WW-1:0]  r_dw;
    logic [1:0]     r_burst;

    // per item
    logic [15:0]    r_pix;
    logic [CW-1:0]  r_wcol;
    logic           r_emit;
    logic           r_inner;
    logic           r_col0;
    logic           r_dsel;
    logic [15:0]    r_res;

    // window of the two rows above and the current pixel
    logic [15:0]    r_win0, r_win1, r_win2, r_win4;

    // output register
    logic           r_out_valid;
    logic [15:0]    r_out_pix;
    logic           r_out_fe;
    logic           r_out_bl;

    logic           w_cfg_we;
    logic [12:0]    w_w13;
    logic [12:0]    w_h13;
    logic [WW-1:0]  w_w;
    logic           w_accept;
    logic           w_fs;
    logic [CW-1:0]  w_c;
    logic [11:0]    w_r;
    logic           w_row_end;
    logic           w_frame_end;
    logic           w_out_free;
    logic [15:0]    w_above, w_mid;
    logic [CW-1:0]  w_above_raddr, w_mid_raddr;
    logic           w_re;
    logic           w_wr;
    logic           w_load;
    logic [15:0]    w_load_pix;
    logic           w_load_fe;
    logic           w_load_bl;
    logic           w_start;
    logic           w_dif_done;
    logic [15:0]    w_dif_pix;
    logic [15:0]    w_nb [4];
    t_dif_cfg       w_dif_cfg;

    // ---------------------------------------------------------------- apb
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 11'd512;
            r_image_height <= 13'd512;
            r_lambda_q12   <= 11'd410;
            r_inv_sigma_sq <= 20'd4444;
        end else if (w_cfg_we) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_HEIGHT: r_image_height <= pwdata[12:0];
                REG_LAMBDA: r_lambda_q12   <= pwdata[10:0];
                REG_ISIGMA: r_inv_sigma_sq <= pwdata[19:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_WIDTH:  prdata = {21'd0, r_image_width};
            REG_HEIGHT: prdata = {19'd0, r_image_height};
            REG_LAMBDA: prdata = {21'd0, r_lambda_q12};
            REG_ISIGMA: prdata = {12'd0, r_inv_sigma_sq};
            default:    prdata = '0;
        endcase
    end

    // frame geometry, clamped to what the buffers and row counter hold
    always_comb begin
        w_w13 = {2'd0, r_image_width};
        if (w_w13 < 13'd3) begin
            w_w13 = 13'd3;
        end else if (w_w13 > 13'(MAX_WIDTH)) begin
            w_w13 = 13'(MAX_WIDTH);
        end
        w_h13 = r_image_height;
        if (w_h13 < 13'd3) begin
            w_h13 = 13'd3;
        end else if (w_h13 > 13'd4096) begin
            w_h13 = 13'd4096;
        end
    end
    assign w_w = WW'(w_w13);

    // ------------------------------------------------------ input position
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_fs          = s_axis_tuser[0];
    assign w_c           = w_fs ? '0 : r_col;
    assign w_r           = w_fs ? '0 : r_row;
    assign w_row_end     = (13'(w_c) >= w_w13 - 13'd1);
    assign w_frame_end   = w_row_end && (13'(w_r) >= w_h13 - 13'd1);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // line buffer read addresses: column 0 fetches the last column above
    always_comb begin
        if (r_state == S_DRAIN) begin
            w_above_raddr = CW'(r_dw - WW'(1));
            w_mid_raddr   = CW'(r_pos - DW'(1));
        end else begin
            w_above_raddr = (w_c == '0) ? CW'(w_w - WW'(1)) : w_c;
            w_mid_raddr   = w_c;
        end
    end

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_re       = 1'b0;
        w_wr       = 1'b0;
        w_start    = 1'b0;
        w_load     = 1'b0;
        w_load_pix = r_res;
        w_load_fe  = 1'b0;
        w_load_bl  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_fs || !r_done) begin
                        w_re    = 1'b1;
                        n_state = S_RD;
                    end else if (r_left != '0) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_RD: begin
                w_wr    = 1'b1;
                w_start = r_emit && r_inner;
                priority if (!r_emit) begin
                    n_state = S_IDLE;
                end else if (r_inner) begin
                    n_state = S_CALC;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CALC: begin
                if (w_dif_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DRAIN: begin
                w_re    = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                w_load_pix = r_dsel ? w_mid : w_above;
                w_load_fe  = (r_left == DW'(1));
                w_load_bl  = w_load_fe || (r_burst == 2'd3);
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = w_load_bl ? S_IDLE : S_DRAIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // position, drain and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
            r_left  <= '0;
            r_pos   <= '0;
            r_dw    <= '0;
            r_burst <= '0;
            r_win0  <= '0;
            r_win1  <= '0;
            r_win2  <= '0;
            r_win4  <= '0;
        end else begin
            if (r_state == S_IDLE && w_accept) begin
                r_burst <= '0;
                if (w_fs || !r_done) begin
                    r_done <= w_frame_end;
                    if (w_row_end) begin
                        r_col <= '0;
                        if (w_frame_end) begin
                            // last column of the row above plus the last row
                            r_left <= DW'(w_w) + DW'(1);
                            r_pos  <= '0;
                            r_dw   <= w_w;
                        end else begin
                            r_row <= w_r + 12'd1;
                        end
                    end else begin
                        r_col <= w_c + CW'(1);
                    end
                    if (w_fs) begin
                        r_row <= w_frame_end ? 12'd0 : (w_row_end ? 12'd1 : 12'd0);
                    end
                end
            end
            if (r_state == S_DWAIT && w_load) begin
                r_left  <= r_left - DW'(1);
                r_pos   <= r_pos + DW'(1);
                r_burst <= r_burst + 2'd1;
            end
            if (r_state == S_RD) begin
                r_win4 <= r_win1;
                r_win0 <= w_above;
                r_win1 <= w_mid;
                r_win2 <= r_pix;
            end
        end
    end

    // per item payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_pix   <= s_axis_tdata;
            r_wcol  <= w_c;
            r_emit  <= ((w_r != '0) && (w_c != '0)) || ((w_r >= 12'd2) && (w_c == '0));
            r_inner <= (w_r >= 12'd2) && (13'(w_c) >= 13'd2);
            r_col0  <= (w_c == '0);
        end
        if (r_state == S_DRAIN) begin
            r_dsel <= (r_pos != '0);
        end
        if (r_state == S_RD) begin
            r_res <= r_col0 ? w_above : r_win1;
        end
        if (r_state == S_CALC && w_dif_done) begin
            r_res <= w_dif_pix;
        end
    end

    // --------------------------------------------------------- line buffers
    ad_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_wcol),
        .i_wdata (w_mid),
        .i_re    (w_re),
        .i_raddr (w_above_raddr),
        .o_rdata (w_above)
    );

    ad_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_wcol),
        .i_wdata (r_pix),
        .i_re    (w_re),
        .i_raddr (w_mid_raddr),
        .o_rdata (w_mid)
    );

    // --------------------------------------------------- diffusion datapath
    // center is the previous middle pixel; north, south, west, east around it
    assign w_nb[0]              = r_win0;
    assign w_nb[1]              = r_win2;
    assign w_nb[2]              = r_win4;
    assign w_nb[3]              = w_mid;
    assign w_dif_cfg.lambda_q12   = r_lambda_q12;
    assign w_dif_cfg.inv_sigma_sq = r_inv_sigma_sq;

    ad_diffuse u_diffuse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_p     (r_win1),
        .i_nb    (w_nb),
        .i_cfg   (w_dif_cfg),
        .o_done  (w_dif_done),
        .o_pix   (w_dif_pix)
    );

    // ------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pix <= w_load_pix;
            r_out_fe  <= w_load_fe;
            r_out_bl  <= w_load_bl;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_pix;
    assign m_axis_tlast    = r_out_fe;
    assign m_axis_tuser[0] = r_out_bl;

    // ------------------------------------------------------------ assertions
    `AD_ASSERT(a_fe_ends_burst, (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0],
        "frame end word without burst end")
    `AD_ASSERT(a_dif_done_in_calc, w_dif_done |-> (r_state == S_CALC),
        "diffusion result outside calc state")
    `AD_NEVER(a_load_over_full, w_load && r_out_valid && !m_axis_tready,
        "output register overwritten while stalled")
    `AD_ASSERT(a_drain_only_done, (r_state == S_DRAIN) |-> (r_done && r_left != '0),
        "drain read without pending words")

endmodule

FILE: verif/diffusion_checker.sv
// ----------------------------------------------------------------------------
// diffusion_checker
// watches the pixel streams and the apb port, predicts each output word of
// the diffusion pass and compares it with what the block sends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diffusion_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] pixel_out
    input  logic        m_axis_tlast,
    input  logic [0:0]  m_axis_tuser,   // [0] burst_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_pending,
    output int          o_fail_count
);
    import ad_pkg::*;

    logic [15:0] exp_q12 [256];
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [10:0] cfg_lambda;
    logic [19:0] cfg_isigma;

    logic [15:0] row_above [1024];
    logic [15:0] row_middle [1024];
    logic [15:0] win [6];
    int          col, row, tail_left, tail_pos, tail_w;
    bit          frame_over;

    logic [15:0] want_pix [$];
    logic        want_end [$];
    logic        want_last [$];

    initial begin
        logic [95:0] acc;
        acc = 96'd1 << 32;
        for (int k = 0; k < 256; k++) begin
            exp_q12[k] = 16'((acc + (96'd1 << 19)) >> 20);
            acc        = (acc * 96'd4162825044) >> 32;
        end
        for (int k = 0; k < 1024; k++) begin
            row_above[k]  = '0;
            row_middle[k] = '0;
        end
        for (int k = 0; k < 6; k++) win[k] = '0;
        cfg_width  = 11'd512;
        cfg_height = 13'd512;
        cfg_lambda = 11'd410;
        cfg_isigma = 20'd4444;
        col = 0; row = 0; tail_left = 0; tail_pos = 0; tail_w = 0;
        frame_over   = 0;
        o_fail_count = 0;
    end

    assign o_pending = want_pix.size();

    // conduction weighted difference toward one neighbor
    function automatic longint flux(logic [15:0] nb, logic [15:0] p);
        longint d, q, c;
        d = longint'(nb) - longint'(p);
        q = (d * d * longint'(cfg_isigma)) >>> 27;
        c = (q < 256) ? longint'(exp_q12[q]) : 0;
        return c * d;
    endfunction

    function automatic logic [15:0] diffused(logic [15:0] p, logic [15:0] n_up,
                                             logic [15:0] n_dn, logic [15:0] n_lf,
                                             logic [15:0] n_rt);
        longint s, v, r;
        s = flux(n_up, p) + flux(n_dn, p) + flux(n_lf, p) + flux(n_rt, p);
        v = longint'(cfg_lambda) * s;
        r = longint'(p) + ((v + (64'sd1 <<< 23)) >>> 24);
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        return 16'(r);
    endfunction

    task automatic pixel_accepted(input logic [15:0] pix, input logic fs);
        logic [15:0] vals [4];
        logic        ends [4];
        int          n, w, h;
        logic [15:0] a, m;
        n = 0;
        w = (cfg_width < 3) ? 3 : ((cfg_width > 1024) ? 1024 : int'(cfg_width));
        h = (cfg_height < 3) ? 3 : ((cfg_height > 4096) ? 4096 : int'(cfg_height));
        if (fs) begin
            row = 0; col = 0; tail_left = 0; tail_pos = 0; frame_over = 0;
        end
        if (!fs && frame_over) begin
            // tail: previous row's last column, then the whole last row
            while (tail_left > 0 && n < 4) begin
                vals[n] = (tail_pos == 0) ? row_above[tail_w - 1] : row_middle[tail_pos - 1];
                tail_left--;
                tail_pos++;
                ends[n] = (tail_left == 0);
                n++;
            end
        end else begin
            a = row_above[col];
            m = row_middle[col];
            row_above[col]  = m;
            row_middle[col] = pix;
            if (row >= 1 && col >= 1) begin
                vals[0] = win[1];
                if (row >= 2 && col >= 2)
                    vals[0] = diffused(win[1], win[0], win[2], win[4], m);
                ends[0] = 0;
                n = 1;
            end else if (row >= 2 && col == 0) begin
                vals[0] = row_above[w - 1];
                ends[0] = 0;
                n = 1;
            end
            win[3] = win[0]; win[4] = win[1]; win[5] = win[2];
            win[0] = a;      win[1] = m;      win[2] = pix;
            if (col >= w - 1) begin
                col = 0;
                if (row >= h - 1) begin
                    frame_over = 1;
                    tail_left  = w + 1;
                    tail_pos   = 0;
                    tail_w     = w;
                end else begin
                    row = row + 1;
                end
            end else begin
                col = col + 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            want_pix.push_back(vals[k]);
            want_end.push_back(ends[k]);
            want_last.push_back(k == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_WIDTH:  cfg_width  = pwdata[10:0];
                    REG_HEIGHT: cfg_height = pwdata[12:0];
                    REG_LAMBDA: cfg_lambda = pwdata[10:0];
                    REG_ISIGMA: cfg_isigma = pwdata[19:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pixel_accepted(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_pix.size() == 0) begin
                    $error("unexpected output word: pixel_out %0d", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    if (m_axis_tdata !== want_pix[0]) begin
                        $error("pixel_out: expected %0d, got %0d", want_pix[0], m_axis_tdata);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== want_end[0]) begin
                        $error("frame_end: expected %0b, got %0b", want_end[0], m_axis_tlast);
                        o_fail_count++;
                    end
                    if (m_axis_tuser[0] !== want_last[0]) begin
                        $error("burst_last: expected %0b, got %0b",
                               want_last[0], m_axis_tuser[0]);
                        o_fail_count++;
                    end
                    void'(want_pix.pop_front());
                    void'(want_end.pop_front());
                    void'(want_last.pop_front());
                end
            end
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives frames and drain words into the diffusion pass over several register
// settings, with bursty input and a stalling output, checked word by word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ad_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] pixel_in
    logic [0:0]  s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] pixel_out
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;   // [0] burst_last
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          pending, fail_count;

    // sender burst state and idling styles
    int          burst_left;
    bit          no_gaps;
    int          stall_mode;
    int          stall_cycles;
    int          rand_words;

    anisotropic_diffusion_pass dut (.*);

    diffusion_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver: switches between always ready, light and heavy stalling
    always @(negedge i_clk) begin
        if (stall_cycles == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stall_cycles <= $urandom_range(20, 300);
        end else begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // one input word, with a random gap whenever a burst runs out
    task automatic send_word(input logic [15:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            no_gaps    = ($urandom_range(0, 4) == 0);
            gap        = no_gaps ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pix;
        s_axis_tuser  = fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait for every expected word, then let the block settle
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int lam, input int isig);
        settle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_LAMBDA, lam);
        reg_write(REG_ISIGMA, isig);
    endtask

    // pixel content: 0 random, 1 extremes checkerboard, 2 smooth around a level
    function automatic logic [15:0] pick_pixel(int style, int r, int c, int level);
        case (style)
            0:       return 16'($urandom);
            1:       return ((r + c) % 2) ? 16'hFFFF : 16'h0000;
            default: return 16'(level + $urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    // whole frame plus the drain words; cut > 0 aborts after that many pixels
    task automatic send_frame(input int w, input int h, input int style, input int cut);
        int level, cw, ch, count;
        level = $urandom_range(3000, 62000);
        cw = (w < 3) ? 3 : ((w > 1024) ? 1024 : w);
        ch = (h < 3) ? 3 : ((h > 4096) ? 4096 : h);
        count = 0;
        for (int r = 0; r < ch; r++) begin
            for (int c = 0; c < cw; c++) begin
                if (cut > 0 && count == cut) return;
                send_word(pick_pixel(style, r, c, level), (r == 0 && c == 0));
                count++;
                rand_words++;
            end
        end
        for (int k = 0; k < (cw + 1 + 3) / 4; k++) begin
            send_word(16'($urandom), 1'b0);
            rand_words++;
        end
        // words after the frame is drained are ignored
        if ($urandom_range(0, 3) == 0) send_word(16'($urandom), 1'b0);
    endtask

    initial begin
        int w, h;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        burst_left = 0; no_gaps = 0; stall_mode = 0; stall_cycles = 0;
        rand_words = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes checkerboard, strongest and zero diffusion
        configure(3, 3, 1024, 1);
        send_frame(3, 3, 1, 0);
        configure(4, 3, 1024, 1048575);
        send_frame(4, 3, 1, 0);
        configure(3, 3, 0, 4444);
        send_frame(3, 3, 0, 0);
        // frame start in the middle of a frame, and right after a drained frame
        configure(5, 4, 1024, 30);
        send_frame(5, 4, 2, 12);
        send_frame(5, 4, 2, 0);
        send_word(16'h1234, 1'b1);
        send_frame(5, 4, 2, 0);

        // random settings and frames
        rand_words = 0;
        while (rand_words < 200) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            configure(w, h, $urandom_range(0, 1024),
                      ($urandom_range(0, 1)) ? $urandom_range(1, 200) : $urandom_range(1, 1048575));
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 7) == 0)
                    send_frame(w, h, 0, $urandom_range(1, w * h - 1));
                else
                    send_frame(w, h, $urandom_range(0, 2), 0);
            end
        end

        // register values below the usable range, clamped by the block
        configure(0, 0, 1024, 1048575);
        send_frame(0, 0, 2, 0);
        configure(1, 2, 410, 4444);
        send_frame(1, 2, 1, 0);

        settle();
        if (fail_count == 0)
            $display("anisotropic_diffusion_pass: match");
        else
            $display("anisotropic_diffusion_pass: mismatch");
        $finish;
    end

    initial begin
        #50ms;
        $display("anisotropic_diffusion_pass: mismatch");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ad_pkg.sv
rtl/ad_ram.sv
rtl/ad_diffuse.sv
rtl/anisotropic_diffusion_pass.sv
verif/diffusion_checker.sv
verif/testbench.sv
